/* hdl/imm_pkg.sv */
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int ADDR_W     = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int DIM_W      = 4;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load_a;
    logic             load_b;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_i;
    logic [IDX_W-1:0] rd_k;
    logic [IDX_W-1:0] rd_j;
    logic             clr_acc;
  } dp_cmd_t;

endpackage

/* hdl/integer_matrix_multiply.sv */
// Signed integer matrix multiplier, A (rows_a x cols_a) times B (rows_b x cols_b).
// Configuration: cfg_we writes cfg_data to register cfg_index (0 rows_a, 1 cols_a,
// 2 rows_b, 3 cols_b); 0 is taken as 1, anything above 8 as 8. Write only while idle.
// Input channel (in_valid/in_ready): func 0 loads A[row][col], func 1 loads B[row][col],
// func 2 starts the product, func 3 is dropped.
// Result channel (out_valid/out_ready): product elements in row-major order, wrapping
// 32-bit dot products; out_last marks the final one. If cols_a != rows_b a single
// transaction with out_dim_error = 1, out_last = 1 and zero data is returned.
// Operation: one shared multiply-accumulate (read, multiply, accumulate stages) steps
// along the inner dimension for each element, then waits in a drain state while the
// last term passes multiply and accumulate, and then emits the element.
// A mismatch result shows in the cycle after start is accepted.
// The block takes one transaction at a time: in_ready is low from start until the
// last result is taken. A stalled receiver holds the current result and the engine.
// Reset (rst_n low, synchronous) returns to idle and sets all dimensions to 1;
// matrix contents are not cleared and must be loaded before use.
module integer_matrix_multiply (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_row,
  input  logic [2:0]  in_col,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_row,
  output logic [2:0]  out_col,
  output logic [31:0] out_product_value,
  output logic        out_last,
  output logic        out_dim_error
);
  import imm_pkg::*;

  dp_cmd_t cmd;

  imm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_last      (out_last),
    .out_dim_error (out_dim_error),
    .cmd           (cmd)
  );

  imm_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .wr_row        (in_row),
    .wr_col        (in_col),
    .wr_value      (in_value),
    .product_value (out_product_value)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dim_error) |-> (out_last && out_product_value == 32'd0))
    else $error("dimension error result malformed");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
    else $error("not idle after last result");

  a_no_rd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.rd_en)
    else $error("memory read issued while idle");

endmodule

/* hdl/imm_datapath.sv */
module imm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  imm_pkg::dp_cmd_t             cmd,
  input  logic [2:0]                   wr_row,
  input  logic [2:0]                   wr_col,
  input  logic [31:0]                  wr_value,
  output logic [31:0]                  product_value
);
  import imm_pkg::*;

  logic [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [DEPTH];

  logic [ADDR_W-1:0]     wr_addr;
  logic                  wr_in_range;
  logic [ADDR_W-1:0]     rd_addr_a;
  logic [ADDR_W-1:0]     rd_addr_b;

  logic [DATA_WIDTH-1:0] a_q_r, b_q_r;
  logic                  v1_r, first1_r;
  logic [DATA_WIDTH-1:0] prod_r, prod_nxt;
  logic                  v2_r, first2_r;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;

  assign wr_in_range = (4'(wr_row) < 4'(MAX_DIM)) && (4'(wr_col) < 4'(MAX_DIM));
  assign wr_addr     = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(MAX_DIM) + ADDR_W'(wr_col));
  assign rd_addr_a   = ADDR_W'(ADDR_W'(cmd.rd_i) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.rd_k));
  assign rd_addr_b   = ADDR_W'(ADDR_W'(cmd.rd_k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.rd_j));

  always_ff @(posedge clk) begin
    if (cmd.load_a && wr_in_range) begin
      mem_a[wr_addr] <= wr_value[DATA_WIDTH-1:0];
    end
    if (cmd.load_b && wr_in_range) begin
      mem_b[wr_addr] <= wr_value[DATA_WIDTH-1:0];
    end
    if (cmd.rd_en) begin
      a_q_r <= mem_a[rd_addr_a];
      b_q_r <= mem_b[rd_addr_b];
    end
  end

  // three-stage MAC: read, multiply, accumulate
  assign prod_nxt = DATA_WIDTH'(a_q_r * b_q_r);
  assign acc_nxt  = first2_r ? prod_r : DATA_WIDTH'(acc_r + prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.rd_first;
    first2_r <= first1_r;
    if (v1_r) begin
      prod_r <= prod_nxt;
    end
    if (cmd.clr_acc) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign product_value = 32'($signed(acc_r));

endmodule

/* hdl/imm_ctrl.sv */
module imm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [3:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_row,
  output logic [2:0]            out_col,
  output logic                  out_last,
  output logic                  out_dim_error,
  output imm_pkg::dp_cmd_t      cmd
);
  import imm_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             drain_r, drain_nxt;
  logic             err_r, err_nxt;
  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [DIM_W-1:0] cfg_dim;
  logic             last_k, last_j, last_i;
  logic             in_acc, out_acc;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_DIM)) begin
      cfg_dim = DIM_W'(MAX_DIM);
    end else begin
      cfg_dim = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      rows_b_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A: rows_a_r <= cfg_dim;
        REG_COLS_A: cols_a_r <= cfg_dim;
        REG_ROWS_B: rows_b_r <= cfg_dim;
        REG_COLS_B: cols_b_r <= cfg_dim;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      drain_r <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
      err_r   <= err_nxt;
    end
  end

  assign last_k  = DIM_W'(DIM_W'(k_r) + DIM_W'(1)) == cols_a_r;
  assign last_j  = DIM_W'(DIM_W'(j_r) + DIM_W'(1)) == cols_b_r;
  assign last_i  = DIM_W'(DIM_W'(i_r) + DIM_W'(1)) == rows_a_r;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign out_row       = i_r;
  assign out_col       = j_r;
  assign out_last      = err_r || (last_i && last_j);
  assign out_dim_error = err_r;

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    drain_nxt    = drain_r;
    err_nxt      = err_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd          = '0;
    cmd.rd_i     = i_r;
    cmd.rd_j     = j_r;
    cmd.rd_k     = k_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          case (in_func)
            FUNC_LOAD_A: cmd.load_a = 1'b1;
            FUNC_LOAD_B: cmd.load_b = 1'b1;
            FUNC_START: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              if (cols_a_r != rows_b_r) begin
                cmd.clr_acc = 1'b1;
                err_nxt     = 1'b1;
                state_nxt   = ST_EMIT;
              end else begin
                err_nxt   = 1'b0;
                state_nxt = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k_r == '0);
        if (last_k) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last term to pass multiply and accumulate
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_acc) begin
          k_nxt = '0;
          if (out_last) begin
            err_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else if (last_j) begin
            j_nxt     = '0;
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = ST_MAC;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
